[design/ucf_pkg.sv]
// ucf_pkg: shared types, byte codes and the code point screen for the
// utf-8 control character filter. No dependencies.

package ucf_pkg;

   // channel payloads
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   // one classified input: up to four output bytes, last_idx is count minus one
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } job_type;

   // front to queue
   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   // queue head to back end
   typedef struct packed {
      logic    avail;
      job_type job;
   } head_type;

   // ascii codes
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_LF    = 8'h0a;
   localparam logic [7:0] BYTE_CR    = 8'h0d;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_DEL   = 8'h7f;

   // sequence lengths
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   // forbidden code points
   localparam logic [20:0] CP_C0_END   = 21'h00001f;
   localparam logic [20:0] CP_DEL      = 21'h00007f;
   localparam logic [20:0] CP_C1_LO    = 21'h000080;
   localparam logic [20:0] CP_C1_HI    = 21'h00009f;
   localparam logic [20:0] CP_ALM      = 21'h00061c;
   localparam logic [20:0] CP_ZW_LO    = 21'h00200b;
   localparam logic [20:0] CP_ZW_HI    = 21'h00200f;
   localparam logic [20:0] CP_EMB_LO   = 21'h00202a;
   localparam logic [20:0] CP_EMB_HI   = 21'h00202e;
   localparam logic [20:0] CP_WJ_LO    = 21'h002060;
   localparam logic [20:0] CP_WJ_HI    = 21'h002064;
   localparam logic [20:0] CP_ISO_LO   = 21'h002066;
   localparam logic [20:0] CP_ISO_HI   = 21'h002069;
   localparam logic [20:0] CP_BOM      = 21'h00feff;

   function automatic logic cp_forbidden(input logic [20:0] cp);
      logic hit;
      hit = (cp <= CP_C0_END) || (cp == CP_DEL)
         || ((cp >= CP_C1_LO) && (cp <= CP_C1_HI))
         || (cp == CP_ALM)
         || ((cp >= CP_ZW_LO) && (cp <= CP_ZW_HI))
         || ((cp >= CP_EMB_LO) && (cp <= CP_EMB_HI))
         || ((cp >= CP_WJ_LO) && (cp <= CP_WJ_HI))
         || ((cp >= CP_ISO_LO) && (cp <= CP_ISO_HI))
         || (cp == CP_BOM);
      return hit;
   endfunction

endpackage

[design/ucf_front.sv]
// ucf_front: accepts input words, tracks the pending multi-byte sequence
// and turns each word into a job of output bytes, if it yields any. Uses ucf_pkg.

module ucf_front
   import ucf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_we,
   input  logic     csr_wdata,
   input  logic     req_valid,
   input  req_type  req_data,
   input  logic     queue_full,
   output logic     req_ready,
   output push_type push_out
);

   logic                  keep_ff;
   logic [2:0][7:0]       held_ff, held_in;
   logic [1:0]            held_count_ff, held_count_in;
   logic [2:0]            needed_ff, needed_in;
   logic [20:0]           accum_ff, accum_in;

   logic                  accept;
   logic                  fresh;
   logic [7:0]            b;
   job_type               job;
   logic                  emit;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.in_byte;

   always_comb begin
      held_in       = held_ff;
      held_count_in = held_count_ff;
      needed_in     = needed_ff;
      accum_in      = accum_ff;
      fresh         = 1'b1;
      emit          = 1'b0;
      job.bytes     = {4{b}};
      job.last_idx  = 2'd0;

      if (needed_ff != LEN_NONE) begin
         if (b[7:6] == 2'b10) begin
            fresh    = 1'b0;
            accum_in = {accum_ff[14:0], b[5:0]};
            if (({1'b0, held_count_ff} + 3'd1) >= needed_ff) begin
               if (!cp_forbidden(accum_in)) begin
                  emit = 1'b1;
                  // held bytes first, then this continuation byte
                  for (int i = 0; i < 3; i++) begin
                     if (2'(i) < held_count_ff) begin
                        job.bytes[i] = held_ff[i];
                     end
                  end
                  job.last_idx = held_count_ff;
               end
               held_count_in = 2'd0;
               needed_in     = LEN_NONE;
               accum_in      = '0;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  if (held_count_ff == 2'(i)) begin
                     held_in[i] = b;
                  end
               end
               held_count_in = held_count_ff + 2'd1;
            end
         end else begin
            // broken sequence: drop pending bytes, reprocess this one
            held_count_in = 2'd0;
            needed_in     = LEN_NONE;
            accum_in      = '0;
         end
      end

      if (fresh) begin
         if (!b[7]) begin
            if (b == BYTE_LF) begin
               emit         = 1'b1;
               job.bytes[0] = keep_ff ? BYTE_LF : BYTE_SPACE;
            end else if (b == BYTE_CR) begin
               emit         = !keep_ff;
               job.bytes[0] = BYTE_SPACE;
            end else if (b == BYTE_TAB || (b >= BYTE_SPACE && b != BYTE_DEL)) begin
               emit = 1'b1;
            end
         end else if (b[7:5] == 3'b110) begin
            needed_in = LEN_TWO;
            accum_in  = {16'd0, b[4:0]};
         end else if (b[7:4] == 4'b1110) begin
            needed_in = LEN_THREE;
            accum_in  = {17'd0, b[3:0]};
         end else if (b[7:3] == 5'b11110) begin
            needed_in = LEN_FOUR;
            accum_in  = {18'd0, b[2:0]};
         end
         if (needed_in != LEN_NONE) begin
            held_in[0]    = b;
            held_count_in = 2'd1;
         end
      end

      // end of text discards a partial sequence
      if (req_data.end_of_text && needed_in != LEN_NONE) begin
         held_count_in = 2'd0;
         needed_in     = LEN_NONE;
         accum_in      = '0;
      end
   end

   assign push_out.push = accept && emit;
   assign push_out.job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff       <= 1'b0;
         held_count_ff <= 2'd0;
         needed_ff     <= LEN_NONE;
         accum_ff      <= '0;
      end else begin
         if (csr_we) begin
            keep_ff <= csr_wdata;
         end
         if (accept) begin
            held_count_ff <= held_count_in;
            needed_ff     <= needed_in;
            accum_ff      <= accum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

[design/ucf_queue.sv]
// ucf_queue: short job queue between front and back end.
// Uses ucf_pkg for the job and handshake structs.

module ucf_queue
   import ucf_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push_in,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head.avail = (count_ff != '0);
   assign head.job  = slots_ff[rd_ptr_ff];
   assign do_pop    = pop && head.avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_in.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_in.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         slots_ff[wr_ptr_ff] <= push_in.job;
      end
   end

endmodule

[design/ucf_back.sv]
// ucf_back: walks the job at the queue head one byte per word on the
// result channel. Uses ucf_pkg.

module ucf_back
   import ucf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   output logic     pop
);

   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       take;

   assign last      = (idx_ff == head.job.last_idx);
   assign rsp_valid = head.avail;
   assign take      = rsp_valid && rsp_ready;
   assign pop       = take && last;

   assign rsp_data.out_byte    = head.job.bytes[idx_ff];
   assign rsp_data.last_of_run = last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[design/utf8_control_char_filter.sv]
// utf8_control_char_filter: top level, front classifier, job queue and
// byte serializer. Uses ucf_pkg, ucf_front, ucf_queue, ucf_back.
//
//   channel  ports                          carries
//   req      req_valid/req_ready/req_data   raw text byte, end_of_text mark
//   rsp      rsp_valid/rsp_ready/rsp_data   filtered byte, last_of_run mark
//   csr      csr_we/csr_wdata               newline keep mode, written at once
//
// one input word per cycle while the job queue has room; each word yields
// zero to four output bytes, and the serializer sends one byte per cycle while rsp_ready is high
// reset is synchronous and clears the pending sequence, queue and newline mode
// a result byte waits at the queue head while rsp_ready is low; the front keeps
// taking words until QUEUE_DEPTH jobs are waiting
// a job is registered in the queue before its bytes leave from the queue head

module utf8_control_char_filter
   import ucf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_we,
   input  logic    csr_wdata,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   push_type push;
   head_type head;
   logic     full;
   logic     pop;

   ucf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .queue_full(full),
      .req_ready (req_ready),
      .push_out  (push)
   );

   ucf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_in(push),
      .pop    (pop),
      .full   (full),
      .head   (head)
   );

   ucf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .pop      (pop)
   );

endmodule

[test/ucf_tracker_pkg.sv]
`timescale 1ns / 100ps
// ucf_tracker_pkg: predicts the filtered byte stream of the utf-8 control
// character filter and checks result words against it. Depends on ucf_pkg.

package ucf_tracker_pkg;
   import ucf_pkg::*;

   class sanitized_byte_tracker;
      bit          keep_lf_mode;
      logic [7:0]  lead_bytes [3];
      int unsigned held_n;
      int unsigned seq_len;
      logic [20:0] code_point;
      rsp_type     expected_bytes [$];
      int unsigned mismatch_count;
      int unsigned bytes_checked;
      int unsigned sequences_passed;
      int unsigned sequences_blocked;

      function new();
         keep_lf_mode = 1'b0;
         mismatch_count = 0;
         bytes_checked = 0;
         sequences_passed = 0;
         sequences_blocked = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         held_n = 0;
         seq_len = 0;
         code_point = '0;
      endfunction

      // controls, c1, bidi and invisible marks
      function bit is_hidden_code(logic [20:0] cp);
         return (cp < 21'h20) || (cp == 21'h7f)
            || (cp >= 21'h80 && cp <= 21'h9f)
            || (cp == 21'h61c)
            || (cp >= 21'h200b && cp <= 21'h200f)
            || (cp >= 21'h202a && cp <= 21'h202e)
            || (cp >= 21'h2060 && cp <= 21'h2064)
            || (cp >= 21'h2066 && cp <= 21'h2069)
            || (cp == 21'hfeff);
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      // accepted input word: work out the bytes it releases
      function void take_word(req_type w);
         logic [7:0] b;
         logic [7:0] outs [4];
         int         k;
         int         i;
         bit         fresh;
         rsp_type    r;
         b = w.in_byte;
         k = 0;
         fresh = 1'b1;
         if (seq_len != 0) begin
            if (b[7:6] == 2'b10) begin
               fresh = 1'b0;
               code_point = {code_point[14:0], b[5:0]};
               if (held_n + 1 >= seq_len) begin
                  if (!is_hidden_code(code_point)) begin
                     for (i = 0; i < held_n; i++) begin
                        outs[k] = lead_bytes[i];
                        k++;
                     end
                     outs[k] = b;
                     k++;
                     sequences_passed++;
                  end else begin
                     sequences_blocked++;
                  end
                  clear_sequence();
               end else begin
                  lead_bytes[held_n] = b;
                  held_n++;
               end
            end else begin
               // broken sequence, byte is handled afresh below
               clear_sequence();
            end
         end
         if (fresh) begin
            if (b < 8'h80) begin
               if (b == BYTE_LF) begin
                  outs[k] = keep_lf_mode ? BYTE_LF : BYTE_SPACE;
                  k++;
               end else if (b == BYTE_CR) begin
                  if (!keep_lf_mode) begin
                     outs[k] = BYTE_SPACE;
                     k++;
                  end
               end else if (b == BYTE_TAB || (b >= BYTE_SPACE && b != BYTE_DEL)) begin
                  outs[k] = b;
                  k++;
               end
            end else if (b[7:5] == 3'b110) begin
               seq_len = int'(LEN_TWO);
               code_point = {16'b0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
               seq_len = int'(LEN_THREE);
               code_point = {17'b0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
               seq_len = int'(LEN_FOUR);
               code_point = {18'b0, b[2:0]};
            end
            if (seq_len != 0) begin
               lead_bytes[0] = b;
               held_n = 1;
            end
         end
         if (w.end_of_text && seq_len != 0)
            clear_sequence();
         for (i = 0; i < k; i++) begin
            r.out_byte = outs[i];
            r.last_of_run = (i == k - 1);
            expected_bytes.push_back(r);
         end
      endfunction

      task flag_mismatch(string what);
         $display("mismatch: %s", what);
         mismatch_count++;
      endtask

      // accepted result word against the oldest expectation
      task match_byte(rsp_type got);
         rsp_type want;
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            flag_mismatch($sformatf("unexpected byte %h last %b", got.out_byte,
                                    got.last_of_run));
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
         if (got.last_of_run !== want.last_of_run)
            flag_mismatch($sformatf("last_of_run %b, want %b on byte %h",
                                    got.last_of_run, want.last_of_run, want.out_byte));
      endtask
   endclass

endpackage

[test/utf8_control_char_filter_test.sv]
`timescale 1ns / 100ps
// utf8_control_char_filter_test: drives text words into the filter, stalls
// both sides at random and checks every result byte. Uses ucf_pkg, ucf_tracker_pkg.

module utf8_control_char_filter_test;
   import ucf_pkg::*;
   import ucf_tracker_pkg::*;

   localparam int IDLE_PERCENT  = 20;
   localparam int EOT_PERCENT   = 4;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;

   // keep mode: printable, tab, lf, cr, nul, del, 2-byte, 4-byte max,
   // zero width space, bad leads, broken sequence
   localparam logic [7:0] FIRST_TEXT [19] = '{
      8'h41, 8'h09, 8'h0a, 8'h0d, 8'h00, 8'h7f, 8'hc3, 8'ha9, 8'hf7, 8'hbf,
      8'hbf, 8'hbf, 8'he2, 8'h80, 8'h8b, 8'h80, 8'hff, 8'he2, 8'h41};
   // space mode: lf, cr, arabic letter mark
   localparam logic [7:0] SECOND_TEXT [4] = '{8'h0a, 8'h0d, 8'hd8, 8'h9c};
   // forbidden code points and their neighbors
   localparam logic [20:0] EDGE_CODES [29] = '{
      21'h0, 21'h1f, 21'h20, 21'h7e, 21'h7f, 21'h80, 21'h9f, 21'ha0, 21'h61b,
      21'h61c, 21'h61d, 21'h200a, 21'h200b, 21'h200f, 21'h2010, 21'h2029,
      21'h202a, 21'h202e, 21'h202f, 21'h205f, 21'h2060, 21'h2064, 21'h2065,
      21'h2066, 21'h2069, 21'h206a, 21'hfefe, 21'hfeff, 21'hff00};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_we = 1'b0;
   logic    csr_wdata = 1'b0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sanitized_byte_tracker tracker = new();
   req_type     text_words [$];
   logic [7:0]  code_bytes [4];
   bit          steady = 1'b0;
   int unsigned words_sent = 0;
   int unsigned quiet_cycles = 0;

   utf8_control_char_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.take_word(req_data);
         if (rsp_valid && rsp_ready)
            tracker.match_byte(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   function automatic void add_word(logic [7:0] b, bit eot);
      req_type w;
      w.in_byte = b;
      w.end_of_text = eot;
      text_words.push_back(w);
   endfunction

   function automatic void add_byte(logic [7:0] b);
      add_word(b, $urandom_range(99) < EOT_PERCENT);
   endfunction

   // push the first n bytes of cp encoded in len bytes (overlong allowed)
   function automatic void add_code(logic [20:0] cp, int len, int n);
      int i;
      case (len)
         2: begin
            code_bytes[0] = {3'b110, cp[10:6]};
            code_bytes[1] = {2'b10, cp[5:0]};
         end
         3: begin
            code_bytes[0] = {4'b1110, cp[15:12]};
            code_bytes[1] = {2'b10, cp[11:6]};
            code_bytes[2] = {2'b10, cp[5:0]};
         end
         default: begin
            code_bytes[0] = {5'b11110, cp[20:18]};
            code_bytes[1] = {2'b10, cp[17:12]};
            code_bytes[2] = {2'b10, cp[11:6]};
            code_bytes[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (i = 0; i < n; i++)
         add_byte(code_bytes[i]);
   endfunction

   // mostly well-formed text with random content, some noise and cut sequences
   function automatic void compose_text(int n);
      int          pick;
      int          len;
      int          min_len;
      logic [20:0] cp;
      while (text_words.size() < n) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            if ($urandom_range(1))
               add_byte(8'($urandom_range(8'h7e, 8'h20)));
            else
               add_byte(8'($urandom_range(8'h7f)));
         end else if (pick < 45) begin
            add_code(21'($urandom_range(21'h7ff)), 2, 2);
         end else if (pick < 60) begin
            add_code(21'($urandom_range(21'hffff)), 3, 3);
         end else if (pick < 70) begin
            add_code(21'($urandom_range(21'h1fffff)), 4, 4);
         end else if (pick < 82) begin
            cp = EDGE_CODES[$urandom_range($size(EDGE_CODES) - 1)];
            min_len = (cp <= 21'h7ff) ? 2 : (cp <= 21'hffff) ? 3 : 4;
            len = $urandom_range(4, min_len);
            add_code(cp, len, len);
         end else if (pick < 90) begin
            len = $urandom_range(4, 2);
            add_code(21'($urandom_range(21'h1fffff)), len, $urandom_range(len - 1, 1));
         end else begin
            add_byte(8'($urandom_range(255)));
         end
      end
   endfunction

   task automatic send_word(input req_type w);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      words_sent++;
   endtask

   task automatic send_text();
      while (text_words.size() != 0)
         send_word(text_words.pop_front());
   endtask

   // drop valid, let every expected byte arrive, then let the pipe settle
   task automatic pause_for_idle();
      req_valid <= 1'b0;
      // the monitor has noted the last accepted word after this edge
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(input bit keep);
      pause_for_idle();
      csr_we <= 1'b1;
      csr_wdata <= keep;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.keep_lf_mode = keep;
   endtask

   initial begin
      int chunk;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_keep(1'b1);
      foreach (FIRST_TEXT[i])
         add_word(FIRST_TEXT[i], 1'b0);
      // partial sequence cut by end of text
      add_word(8'hc3, 1'b1);
      send_text();

      write_keep(1'b0);
      foreach (SECOND_TEXT[i])
         add_word(SECOND_TEXT[i], 1'b0);
      send_text();

      for (chunk = 0; chunk < 4; chunk++) begin
         write_keep(chunk == 0 ? 1'b1 : chunk == 1 ? 1'b0 : 1'($urandom_range(1)));
         steady <= (chunk == 2);
         compose_text(100);
         send_text();
      end
      pause_for_idle();

      if (tracker.pending() != 0)
         tracker.flag_mismatch($sformatf("%0d expected bytes never arrived",
                                         tracker.pending()));
      $display("sent %0d words in both newline modes: %0d sequences passed, %0d blocked",
               words_sent, tracker.sequences_passed, tracker.sequences_blocked);
      $display("checked %0d result bytes, %0d mismatches", tracker.bytes_checked,
               tracker.mismatch_count);
      if (tracker.mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
